[sv/bdlz_pkg.sv]
// Shared types and constants for the backward LZSS decompressor.
package bdlz_pkg;

    localparam int CAP_W  = 24;
    localparam int LEN_W  = 5;
    localparam int DIST_W = 13;

    localparam logic [7:0]        FLAG_MSB_MASK = 8'h80;
    localparam logic [11:0]       DIST_MASK     = 12'h0FFF;
    localparam int                DIST_SHIFT    = 12;
    localparam logic [LEN_W-1:0]  MIN_MATCH     = 5'd3;
    localparam logic [3:0]        FLAGS_PER_CTL = 4'd8;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_FAR    = 2'd1;
    localparam logic [1:0] ERR_CAP    = 2'd2;
    localparam logic [1:0] ERR_TRUNC  = 2'd3;

    localparam logic [1:0] EMIT_LIT   = 2'd0;
    localparam logic [1:0] EMIT_COPY  = 2'd1;
    localparam logic [1:0] EMIT_MARK  = 2'd2;

    typedef struct packed {
        logic       take_input;
        logic       load_flags;
        logic       shift_flags;
        logic       clear_pending;
        logic       set_failed;
        logic       start_copy;
        logic       copy_read;
        logic       emit;
        logic [1:0] emit_kind;
        logic [1:0] emit_err;
        logic       run_last;
        logic       stream_end;
        logic       clear_stream;
    } cmd_t;

    typedef struct packed {
        logic failed;
        logic pending;
        logic overflow;
        logic too_far;
        logic full;
        logic flags_empty;
        logic flag_msb;
        logic copy_last;
        logic out_free;
        logic last;
    } sts_t;

endpackage

[sv/bdlz_ram.sv]
// Generic simple dual-port RAM with registered read.
module bdlz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4098
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/bdlz_ctrl.sv]
// Controller state machine for the backward LZSS decompressor.
module bdlz_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  bdlz_pkg::sts_t sts,
    output bdlz_pkg::cmd_t cmd
);
    import bdlz_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECODE  = 3'd1;
    localparam logic [2:0] ST_FINISH  = 3'd2;
    localparam logic [2:0] ST_COPY_RD = 3'd3;
    localparam logic [2:0] ST_COPY_WR = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_input = 1'b1;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.failed)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.pending)
                begin
                    if (!sts.overflow && !sts.too_far)
                    begin
                        cmd.clear_pending = 1'b1;
                        cmd.start_copy    = 1'b1;
                        state_next        = ST_COPY_RD;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.clear_pending = 1'b1;
                        cmd.set_failed    = 1'b1;
                        cmd.emit          = 1'b1;
                        cmd.emit_kind     = EMIT_MARK;
                        cmd.emit_err      = sts.overflow ? ERR_CAP : ERR_FAR;
                        cmd.run_last      = 1'b1;
                        cmd.stream_end    = sts.last;
                        cmd.clear_stream  = sts.last;
                        state_next        = ST_IDLE;
                    end
                end
                else if (sts.full)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.flags_empty)
                begin
                    cmd.load_flags = 1'b1;
                    state_next     = ST_FINISH;
                end
                else if (sts.flag_msb)
                begin
                    cmd.shift_flags = 1'b1;
                    state_next      = ST_FINISH;
                end
                else if (sts.out_free)
                begin
                    cmd.shift_flags  = 1'b1;
                    cmd.emit         = 1'b1;
                    cmd.emit_kind    = EMIT_LIT;
                    cmd.emit_err     = ERR_OK;
                    cmd.run_last     = 1'b1;
                    cmd.stream_end   = sts.last;
                    cmd.clear_stream = sts.last;
                    state_next       = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (!sts.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit         = 1'b1;
                    cmd.emit_kind    = EMIT_MARK;
                    cmd.emit_err     = (sts.pending && !sts.failed) ? ERR_TRUNC : ERR_OK;
                    cmd.run_last     = 1'b1;
                    cmd.stream_end   = 1'b1;
                    cmd.clear_stream = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_COPY_RD:
            begin
                cmd.copy_read = 1'b1;
                state_next    = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit         = 1'b1;
                    cmd.emit_kind    = EMIT_COPY;
                    cmd.emit_err     = ERR_OK;
                    cmd.run_last     = sts.copy_last;
                    cmd.stream_end   = sts.copy_last && sts.last;
                    cmd.clear_stream = sts.copy_last && sts.last;
                    state_next       = sts.copy_last ? ST_IDLE : ST_COPY_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/bdlz_dp.sv]
// Datapath for the backward LZSS decompressor: stream state, history, output register.
module bdlz_dp #(
    parameter int HISTORY_DEPTH = 4098,
    parameter int COUNT_WIDTH   = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [7:0]                 in_byte,
    input  logic                       last_in,
    input  logic                       cfg_we,
    input  logic [bdlz_pkg::CAP_W-1:0] cfg_data,
    input  bdlz_pkg::cmd_t             cmd,
    output bdlz_pkg::sts_t             sts,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 out_byte,
    output logic                       byte_valid,
    output logic                       run_last,
    output logic                       stream_end,
    output logic [1:0]                 error_code
);
    import bdlz_pkg::*;

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W+1)'(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(HISTORY_DEPTH - 1);

    logic [7:0]             byte_reg;
    logic                   last_reg;
    logic [7:0]             flag_bits_reg;
    logic [3:0]             flags_left_reg;
    logic                   pending_reg;
    logic [7:0]             token_high_reg;
    logic                   failed_reg;
    logic [COUNT_WIDTH-1:0] produced_reg;
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [LEN_W-1:0]       count_reg;
    logic [CAP_W-1:0]       cap_reg;

    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   byte_valid_reg;
    logic                   run_last_reg;
    logic                   stream_end_reg;
    logic [1:0]             error_code_reg;

    logic [COUNT_WIDTH-1:0] cap;
    logic [LEN_W-1:0]       len;
    logic [DIST_W-1:0]      ref_dist;
    logic [COUNT_WIDTH:0]   sum;
    logic [PTR_W:0]         dist_ext;
    logic [PTR_W:0]         wr_ext;
    logic [7:0]             ram_rdata;
    logic [7:0]             emit_data;
    logic                   hist_we;
    logic                   out_free;

    generate
        if (COUNT_WIDTH >= CAP_W)
        begin : g_cap_wide
            assign cap = COUNT_WIDTH'(cap_reg);
        end
        else
        begin : g_cap_clamp
            assign cap = (|cap_reg[CAP_W-1:COUNT_WIDTH]) ? '1 : cap_reg[COUNT_WIDTH-1:0];
        end
    endgenerate

    assign len      = LEN_W'(token_high_reg[7:4]) + MIN_MATCH;
    assign ref_dist = DIST_W'(({token_high_reg, byte_reg} & {4'h0, DIST_MASK}))
                      + DIST_W'(MIN_MATCH);
    assign sum      = {1'b0, produced_reg} + (COUNT_WIDTH+1)'(len);
    assign dist_ext = (PTR_W+1)'(ref_dist);
    assign wr_ext   = {1'b0, wr_ptr_reg};
    assign rd_ptr_next = (wr_ext >= dist_ext) ? PTR_W'(wr_ext - dist_ext)
                                              : PTR_W'(wr_ext + DEPTH_EXT - dist_ext);

    assign out_free = !out_valid_reg || !out_stall;
    assign hist_we  = cmd.emit && (cmd.emit_kind != EMIT_MARK);
    assign emit_data = (cmd.emit_kind == EMIT_COPY) ? ram_rdata : byte_reg;

    always_comb
    begin
        sts             = '0;
        sts.failed      = failed_reg;
        sts.pending     = pending_reg;
        sts.overflow    = sum > {1'b0, cap};
        sts.too_far     = (COUNT_WIDTH+1)'(ref_dist) > {1'b0, produced_reg};
        sts.full        = produced_reg >= cap;
        sts.flags_empty = (flags_left_reg == 4'd0);
        sts.flag_msb    = |(flag_bits_reg & FLAG_MSB_MASK);
        sts.copy_last   = (count_reg == LEN_W'(1));
        sts.out_free    = out_free;
        sts.last        = last_reg;
    end

    bdlz_ram #(
        .WIDTH(8),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wr_ptr_reg),
        .wdata (emit_data),
        .re    (cmd.copy_read),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_input)
        begin
            byte_reg <= in_byte;
            last_reg <= last_in;
        end
        if (cmd.start_copy)
        begin
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= len;
        end
        else if (cmd.emit && cmd.emit_kind == EMIT_COPY)
        begin
            rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_reg  <= count_reg - 1'b1;
        end
        if (cmd.emit)
        begin
            out_byte_reg   <= (cmd.emit_kind == EMIT_MARK) ? 8'h00 : emit_data;
            byte_valid_reg <= (cmd.emit_kind != EMIT_MARK);
            run_last_reg   <= cmd.run_last;
            stream_end_reg <= cmd.stream_end;
            error_code_reg <= cmd.emit_err;
        end
    end

    // stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            pending_reg    <= 1'b0;
            token_high_reg <= '0;
            failed_reg     <= 1'b0;
            produced_reg   <= '0;
            wr_ptr_reg     <= '0;
            cap_reg        <= '1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.clear_stream)
            begin
                flag_bits_reg  <= '0;
                flags_left_reg <= '0;
                pending_reg    <= 1'b0;
                token_high_reg <= '0;
                failed_reg     <= 1'b0;
                produced_reg   <= '0;
                wr_ptr_reg     <= '0;
            end
            else
            begin
                if (cmd.load_flags)
                begin
                    flag_bits_reg  <= byte_reg;
                    flags_left_reg <= FLAGS_PER_CTL;
                end
                else if (cmd.shift_flags)
                begin
                    flag_bits_reg  <= {flag_bits_reg[6:0], 1'b0};
                    flags_left_reg <= flags_left_reg - 1'b1;
                    if (sts.flag_msb)
                    begin
                        token_high_reg <= byte_reg;
                        pending_reg    <= 1'b1;
                    end
                end
                if (cmd.clear_pending)
                begin
                    pending_reg <= 1'b0;
                end
                if (cmd.set_failed)
                begin
                    failed_reg <= 1'b1;
                end
                if (hist_we)
                begin
                    produced_reg <= produced_reg + 1'b1;
                    wr_ptr_reg   <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign run_last   = run_last_reg;
    assign stream_end = stream_end_reg;
    assign error_code = error_code_reg;

endmodule

[sv/backward_lzss_decompressor.sv]
// Top level of the backward LZSS decompressor.
//
//   Channel  Direction  Handshake             Payload
//   in       sink       in_valid / in_stall   in_byte, last_in
//   out      source     out_valid / out_stall out_byte, byte_valid, run_last,
//                                             stream_end, error_code
//   cfg      sink       cfg_valid / cfg_ready cfg_data (out_capacity)
//
// One item at a time: a control byte, a token high byte or an ignored byte
// passes DECODE then FINISH, a literal or error is emitted from DECODE, and each
// byte of a back reference (len 3..18) is a history RAM read then a write.
// Reset clears all stream state and sets out_capacity to all ones; history
// is not cleared. A stall on out holds the controller in its emitting state.
module backward_lzss_decompressor #(
    parameter int HISTORY_DEPTH = 4098,
    parameter int COUNT_WIDTH   = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        run_last,
    output logic        stream_end,
    output logic [1:0]  error_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data
);
    import bdlz_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bdlz_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    bdlz_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .last_in    (last_in),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (CAP_W'(cfg_data)),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .stream_end (stream_end),
        .error_code (error_code)
    );

endmodule

[sv/bdlz_checker.sv]
// Port-level assertions for the backward LZSS decompressor, with bind.
module bdlz_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic        byte_valid,
    input logic        run_last,
    input logic        stream_end,
    input logic [1:0]  error_code
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(error_code)
            && $stable(run_last) && $stable(stream_end) && $stable(byte_valid))
        else $error("stalled transfer changed");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> run_last)
        else $error("stream_end without run_last");

    a_data_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> error_code == 2'd0)
        else $error("data byte carries error");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'h00 && run_last)
        else $error("marker malformed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

endmodule

bind backward_lzss_decompressor bdlz_checker u_bdlz_checker (.*);

[tb/tb.sv]
// Self-checking testbench for the backward LZSS decompressor: streamed stimulus, predicted output.
module tb;
    import bdlz_pkg::*;

    localparam int HIST_DEPTH = 4098;
    localparam int SETTLE     = 50;
    localparam int LIMIT      = 400000;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       run_last;
        logic       stream_end;
        logic [1:0] err;
    } out_beat_t;

    class lzss_tracker;
        out_beat_t       expected_out[$];
        out_beat_t       step_out[$];
        logic [7:0]      hist[HIST_DEPTH];
        longint unsigned produced;
        logic [7:0]      flag_bits;
        int              flags_left;
        bit              tok_pending;
        logic [7:0]      tok_high;
        bit              failed;
        logic [CAP_W-1:0] capacity;
        int              errors;

        function new();
            capacity = '1;
            errors = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            produced = 0;
            flag_bits = 8'h00;
            flags_left = 0;
            tok_pending = 1'b0;
            tok_high = 8'h00;
            failed = 1'b0;
        endfunction

        function void emit_byte(logic [7:0] b);
            hist[produced % HIST_DEPTH] = b;
            produced++;
            step_out.push_back('{b, 1'b1, 1'b0, 1'b0, ERR_OK});
        endfunction

        function void emit_fail(logic [1:0] code);
            step_out.push_back('{8'h00, 1'b0, 1'b0, 1'b0, code});
            failed = 1'b1;
        endfunction

        // Predicts the output run of one compressed byte; returns 1 unless the byte is ignored.
        function bit decode_byte(logic [7:0] b, logic last);
            int unsigned len;
            int unsigned back_dist;
            int unsigned j;
            bit          used;
            bit          set;
            used = !failed && (tok_pending || produced < capacity);
            step_out.delete();
            if (!failed) begin
                if (tok_pending) begin
                    len = int'(tok_high[7:4]) + 3;
                    back_dist = int'({tok_high[3:0], b}) + 3;
                    tok_pending = 1'b0;
                    if (produced + len > capacity)
                        emit_fail(ERR_CAP);
                    else if (back_dist > produced)
                        emit_fail(ERR_FAR);
                    else
                        for (j = 0; j < len; j++)
                            emit_byte(hist[(produced - back_dist) % HIST_DEPTH]);
                end else if (produced >= capacity) begin
                    // output full, byte dropped
                end else if (flags_left == 0) begin
                    flag_bits = b;
                    flags_left = 8;
                end else begin
                    set = flag_bits[7];
                    flag_bits = flag_bits << 1;
                    flags_left--;
                    if (set) begin
                        tok_high = b;
                        tok_pending = 1'b1;
                    end else begin
                        emit_byte(b);
                    end
                end
            end
            if (last) begin
                if (!failed && tok_pending)
                    emit_fail(ERR_TRUNC);
                if (step_out.size() == 0)
                    step_out.push_back('{8'h00, 1'b0, 1'b0, 1'b0, ERR_OK});
                step_out[step_out.size() - 1].stream_end = 1'b1;
                clear_stream();
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].run_last = 1'b1;
            foreach (step_out[k])
                expected_out.push_back(step_out[k]);
            return used;
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_out(out_beat_t got);
            out_beat_t want;
            if (expected_out.size() == 0) begin
                $error("unexpected output transfer: out_byte=0x%0h byte_valid=%0b error_code=%0d",
                       got.data, got.has_data, got.err);
                errors++;
                return;
            end
            want = expected_out.pop_front();
            compare("out_byte", want.data, got.data);
            compare("byte_valid", want.has_data, got.has_data);
            compare("run_last", want.run_last, got.run_last);
            compare("stream_end", want.stream_end, got.stream_end);
            compare("error_code", want.err, got.err);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        last_in = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        stream_end;
    logic [1:0]  error_code;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data = 24'h0;

    lzss_tracker board;
    logic [7:0]  stream_q[$];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          useful_items = 0;
    int          cycles = 0;

    backward_lzss_decompressor #(
        .HISTORY_DEPTH(HIST_DEPTH),
        .COUNT_WIDTH(CAP_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_byte(in_byte),
        .last_in(last_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .byte_valid(byte_valid),
        .run_last(run_last),
        .stream_end(stream_end),
        .error_code(error_code),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_out('{out_byte, byte_valid, run_last, stream_end, error_code});

    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        last_in <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (board.decode_byte(b, last))
            useful_items++;
        @(negedge clk);
    endtask

    // Hold off input until every predicted transfer has come out, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_out.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [23:0] c);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.capacity = c;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_stream();
        int i;
        for (i = 0; i < stream_q.size(); i++)
        begin
            if ($urandom_range(0, 39) == 0)
                drain();
            send_item(stream_q[i], i == stream_q.size() - 1);
        end
    endtask

    // Kinds: 0 noise, 1 ends on a control byte, 2 reference too far, 3 cut-off token, else clean.
    task automatic random_stream();
        logic [7:0]  grp[$];
        logic [7:0]  ctl;
        logic [11:0] d;
        logic [3:0]  nib;
        int          kind;
        int          units;
        int          far_at;
        int          out_len;
        int          span;
        int          u;
        int          i;
        bit          tok;
        stream_q.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom));
        end
        else
        begin
            units = $urandom_range(1, 30);
            if (kind == 1)
                units = ((units + 7) / 8) * 8;
            far_at = (kind == 2) ? $urandom_range(0, units - 1) : -1;
            out_len = 0;
            u = 0;
            while (u < units)
            begin
                span = (units - u < 8) ? units - u : 8;
                ctl = 8'($urandom);
                grp.delete();
                for (i = 0; i < span; i++)
                begin
                    tok = (u + i == far_at) || (kind == 3 && u + i == units - 1)
                          || (out_len >= 3 && $urandom_range(0, 1) == 1);
                    ctl[7 - i] = tok;
                    if (!tok)
                    begin
                        grp.push_back(8'($urandom));
                        out_len++;
                    end
                    else
                    begin
                        nib = 4'($urandom);
                        if (kind == 3 && u + i == units - 1)
                            grp.push_back({nib, 4'($urandom)});
                        else
                        begin
                            if (u + i == far_at)
                                d = 12'($urandom_range(out_len < 2 ? 0 : out_len - 2, 4095));
                            else
                                d = 12'($urandom_range(0, (out_len > 4098 ? 4098 : out_len) - 3));
                            grp.push_back({nib, d[11:8]});
                            grp.push_back(d[7:0]);
                            out_len += int'(nib) + 3;
                        end
                    end
                end
                stream_q.push_back(ctl);
                foreach (grp[k])
                    stream_q.push_back(grp[k]);
                u += span;
            end
            if (kind == 1)
                stream_q.push_back(8'($urandom));
        end
        send_stream();
    endtask

    initial
    begin
        logic [23:0] cap;
        int          ph;
        int          streams;
        board = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // literals, longest copy at shortest distance
        stream_q = '{8'h10, 8'hFF, 8'h00, 8'h5A, 8'hF0, 8'h00, 8'hA5};
        send_stream();
        drain();
        // farthest reference on empty output, then end marker after failure
        stream_q = '{8'h80, 8'h0F, 8'hFF, 8'h34};
        send_stream();
        // token high byte on the final byte
        stream_q = '{8'h10, 8'h01, 8'h02, 8'h03, 8'h00};
        send_stream();
        // set flags with nothing after them
        stream_q = '{8'hFF};
        send_stream();
        // copy would pass the capacity
        write_capacity(24'd4);
        stream_q = '{8'h10, 8'h61, 8'h62, 8'h63, 8'h00, 8'h00};
        send_stream();
        // output full, remaining bytes dropped
        write_capacity(24'd2);
        stream_q = '{8'h00, 8'h71, 8'h72, 8'h73};
        send_stream();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: cap = 24'hFFFFFF;
                1: cap = 24'd0;
                2: cap = 24'd40;
                3: cap = 24'($urandom_range(8, 300));
                5: cap = 24'($urandom);
                6: cap = 24'd1;
                default: cap = 24'hFFFFFF;
            endcase
            write_capacity(cap);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 51; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 51; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            useful_items = 0;
            streams = 0;
            while (useful_items < 40 && streams < ((cap < 8) ? 2 : 40))
            begin
                random_stream();
                streams++;
            end
        end

        drain();
        if (board.errors == 0 && board.expected_out.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
